>>> src/htcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htcs_pkg
// Shared types and constants of the token character scanner.
// ----------------------------------------------------------------------------
package htcs_pkg;

    localparam int MAX_NEST_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH        = 2;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START, PH_MAIN, PH_SLASH, PH_LINE, PH_TODO, PH_BLOCK,
        PH_BLOCK_STAR, PH_NEST, PH_NEST_PLUS, PH_NEST_SLASH, PH_BANG, PH_ZERO,
        PH_LIT_BIN, PH_LIT_OCT, PH_LIT_DEC, PH_LIT_HEX, PH_ESC_SEL, PH_ESC_HEX,
        PH_ESC_OCT, PH_ESC_NAME, PH_EXP_SIGN, PH_EXP_DIG
    } phase_t;

    typedef enum logic [3:0] {
        K_NONE, K_STRING, K_ESCAPE, K_EXPONENT, K_LINE, K_BLOCK, K_NEST, K_TODO,
        K_BIN_PFX, K_OCT_PFX, K_HEX_PFX, K_BIN, K_OCT, K_DEC, K_HEX
    } kind_t;

    localparam int W_STR  = 0;
    localparam int W_EXP  = 1;
    localparam int W_BIN  = 2;
    localparam int W_OCT  = 3;
    localparam int W_DEC  = 4;
    localparam int W_HEX  = 5;
    localparam int W_TODO = 6;
    localparam int W_ERR  = 7;

    typedef struct packed {
        logic [7:0] chr;
        logic       begin_scan;
        logic       eoi;
        logic [7:0] wants;
    } item_t;

    typedef struct packed {
        logic       consumed;
        logic       skipped;
        logic       done;
        kind_t      kind;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d;
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h37;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic kind_t eof_kind(input phase_t ph);
        kind_t k;
        unique case (ph)
            PH_ZERO, PH_LIT_DEC:                 k = K_DEC;
            PH_LINE:                             k = K_LINE;
            PH_TODO:                             k = K_TODO;
            PH_BLOCK, PH_BLOCK_STAR:             k = K_BLOCK;
            PH_NEST, PH_NEST_PLUS, PH_NEST_SLASH: k = K_NEST;
            PH_LIT_BIN:                          k = K_BIN;
            PH_LIT_OCT:                          k = K_OCT;
            PH_LIT_HEX:                          k = K_HEX;
            PH_ESC_SEL, PH_ESC_HEX, PH_ESC_OCT, PH_ESC_NAME: k = K_ESCAPE;
            PH_EXP_SIGN, PH_EXP_DIG:             k = K_EXPONENT;
            default:                             k = K_NONE;
        endcase
        return k;
    endfunction

endpackage

>>> src/htcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htcs_front
// Input stage: takes stream transactions, unpacks them into queue entries.
// ----------------------------------------------------------------------------
module htcs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,
    input  logic                 s_axis_tuser,
    output logic                 q_valid,
    input  logic                 q_ready,
    output htcs_pkg::item_t      q_item
);

    logic            valid_reg;
    htcs_pkg::item_t item_reg;

    assign s_axis_tready = !valid_reg || q_ready;
    assign q_valid       = valid_reg;
    assign q_item        = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg.chr        <= s_axis_tdata[7:0];
            item_reg.eoi        <= s_axis_tdata[8];
            item_reg.wants      <= s_axis_tdata[16:9];
            item_reg.begin_scan <= s_axis_tuser;
        end
    end

endmodule

>>> src/htcs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htcs_queue
// Short queue between the input stage and the scan engine.
// ----------------------------------------------------------------------------
module htcs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  htcs_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output htcs_pkg::item_t out_item
);

    localparam int AW = $clog2(htcs_pkg::QUEUE_DEPTH);

    htcs_pkg::item_t mem_reg [htcs_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   wptr_reg, rptr_reg;
    logic [AW:0]     count_reg;
    logic            push, pop;

    assign in_ready  = count_reg != (AW+1)'(htcs_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

endmodule

>>> src/htcs_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htcs_engine
// Scan engine: phase machine stepping one character per transaction, with
// an output register toward the result stream.
// ----------------------------------------------------------------------------
module htcs_engine #(
    parameter int MAX_NEST_DEPTH = htcs_pkg::MAX_NEST_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  htcs_pkg::item_t in_item,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [7:0]      m_axis_tdata
);

    htcs_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]        wants_reg, wants_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [4:0]        depth_reg, depth_next;
    logic              ovalid_reg;
    htcs_pkg::result_t res_reg, res;

    htcs_pkg::phase_t  ph;
    logic [7:0]        w, c;
    logic              err, fin;
    logic              fire;

    assign in_ready      = !ovalid_reg || m_axis_tready;
    assign fire          = in_valid && in_ready;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {1'b0, res_reg.kind, res_reg.done, res_reg.skipped,
                            res_reg.consumed};

    always_comb
    begin
        w          = in_item.begin_scan ? in_item.wants : wants_reg;
        ph         = in_item.begin_scan ? htcs_pkg::PH_START : phase_reg;
        cnt_next   = in_item.begin_scan ? 4'd0 : cnt_reg;
        depth_next = in_item.begin_scan ? 5'd0 : depth_reg;
        wants_next = w;
        c          = in_item.chr;
        err        = w[htcs_pkg::W_ERR];
        res        = '0;
        fin        = 1'b0;
        phase_next = ph;
        if (ph == htcs_pkg::PH_IDLE)
        begin
            fin = 1'b0;
        end
        else if (in_item.eoi)
        begin
            res.kind = htcs_pkg::eof_kind(ph);
            fin      = 1'b1;
        end
        else
        begin
            // fall-through phases are resolved first
            if (ph == htcs_pkg::PH_START)
            begin
                if (w[htcs_pkg::W_STR] && !err)
                begin
                    if (c == 8'h22)
                    begin
                        fin = 1'b1;
                    end
                    else if (c == 8'h5c)
                    begin
                        res.consumed = 1'b1;
                        phase_next   = htcs_pkg::PH_ESC_SEL;
                    end
                    else
                    begin
                        res.consumed = 1'b1;
                        res.kind     = htcs_pkg::K_STRING;
                        fin          = 1'b1;
                    end
                    ph = htcs_pkg::PH_IDLE;
                end
                else if (w[htcs_pkg::W_EXP] && !err &&
                         (c == 8'h65 || c == 8'h45 || c == 8'h70 || c == 8'h50))
                begin
                    res.consumed = 1'b1;
                    phase_next   = htcs_pkg::PH_EXP_SIGN;
                    ph           = htcs_pkg::PH_IDLE;
                end
                else
                begin
                    ph = htcs_pkg::PH_MAIN;
                end
            end
            if (ph == htcs_pkg::PH_MAIN)
            begin
                if (!(w[htcs_pkg::W_BIN] || w[htcs_pkg::W_OCT] || w[htcs_pkg::W_HEX]) &&
                    htcs_pkg::is_ws(c))
                begin
                    res.skipped = 1'b1;
                    phase_next  = htcs_pkg::PH_MAIN;
                    ph          = htcs_pkg::PH_IDLE;
                end
                else if (c == 8'h2f)
                begin
                    res.consumed = 1'b1;
                    phase_next   = htcs_pkg::PH_SLASH;
                    ph           = htcs_pkg::PH_IDLE;
                end
                else if (c == 8'h21)
                begin
                    res.consumed = 1'b1;
                    phase_next   = htcs_pkg::PH_BANG;
                    ph           = htcs_pkg::PH_IDLE;
                end
                else if (c == 8'h30)
                begin
                    res.consumed = 1'b1;
                    phase_next   = htcs_pkg::PH_ZERO;
                    ph           = htcs_pkg::PH_IDLE;
                end
                else if (c >= 8'h31 && c <= 8'h39)
                begin
                    priority if (w[htcs_pkg::W_BIN])      ph = htcs_pkg::PH_LIT_BIN;
                    else if (w[htcs_pkg::W_OCT])          ph = htcs_pkg::PH_LIT_OCT;
                    else if (w[htcs_pkg::W_DEC])          ph = htcs_pkg::PH_LIT_DEC;
                    else if (w[htcs_pkg::W_HEX])          ph = htcs_pkg::PH_LIT_HEX;
                    else
                    begin
                        fin = 1'b1;
                        ph  = htcs_pkg::PH_IDLE;
                    end
                end
                else if (w[htcs_pkg::W_HEX] && htcs_pkg::is_hex(c))
                begin
                    ph = htcs_pkg::PH_LIT_HEX;
                end
                else
                begin
                    fin = 1'b1;
                    ph  = htcs_pkg::PH_IDLE;
                end
            end
            if (ph == htcs_pkg::PH_BLOCK_STAR)
            begin
                if (c == 8'h2f)
                begin
                    res.consumed = 1'b1;
                    res.kind     = htcs_pkg::K_BLOCK;
                    fin          = 1'b1;
                    ph           = htcs_pkg::PH_IDLE;
                end
                else
                begin
                    ph = htcs_pkg::PH_BLOCK;
                end
            end
            if (ph == htcs_pkg::PH_NEST_PLUS)
            begin
                if (c == 8'h2f)
                begin
                    res.consumed = 1'b1;
                    depth_next   = (depth_reg > 5'd0) ? depth_reg - 5'd1 : 5'd0;
                    if (depth_next == 5'd0)
                    begin
                        res.kind = htcs_pkg::K_NEST;
                        fin      = 1'b1;
                    end
                    else
                    begin
                        phase_next = htcs_pkg::PH_NEST;
                    end
                    ph = htcs_pkg::PH_IDLE;
                end
                else
                begin
                    ph = htcs_pkg::PH_NEST;
                end
            end
            if (ph == htcs_pkg::PH_NEST_SLASH)
            begin
                if (c == 8'h2b)
                begin
                    res.consumed = 1'b1;
                    if (depth_reg < 5'(MAX_NEST_DEPTH))
                    begin
                        depth_next = depth_reg + 5'd1;
                    end
                    phase_next = htcs_pkg::PH_NEST;
                    ph         = htcs_pkg::PH_IDLE;
                end
                else
                begin
                    ph = htcs_pkg::PH_NEST;
                end
            end
            if (ph == htcs_pkg::PH_ZERO)
            begin
                if (c == 8'h62 || c == 8'h6f || c == 8'h78)
                begin
                    res.consumed = 1'b1;
                    res.kind     = (c == 8'h62) ? htcs_pkg::K_BIN_PFX :
                                   (c == 8'h6f) ? htcs_pkg::K_OCT_PFX : htcs_pkg::K_HEX_PFX;
                    fin          = 1'b1;
                    ph           = htcs_pkg::PH_IDLE;
                end
                else
                begin
                    ph = htcs_pkg::PH_LIT_DEC;
                end
            end
            if (ph == htcs_pkg::PH_EXP_SIGN)
            begin
                if (c == 8'h2d || c == 8'h2b)
                begin
                    res.consumed = 1'b1;
                    phase_next   = htcs_pkg::PH_EXP_DIG;
                    ph           = htcs_pkg::PH_IDLE;
                end
                else
                begin
                    ph = htcs_pkg::PH_EXP_DIG;
                end
            end
            // terminal phases
            unique case (ph)
                htcs_pkg::PH_SLASH:
                begin
                    if (c == 8'h2f || c == 8'h2a || c == 8'h2b)
                    begin
                        res.consumed = 1'b1;
                        phase_next   = (c == 8'h2f) ? htcs_pkg::PH_LINE :
                                       (c == 8'h2a) ? htcs_pkg::PH_BLOCK : htcs_pkg::PH_NEST;
                        if (c == 8'h2b)
                        begin
                            depth_next = 5'd1;
                        end
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                htcs_pkg::PH_BANG:
                begin
                    if (c == 8'h21 && w[htcs_pkg::W_TODO])
                    begin
                        res.consumed = 1'b1;
                        phase_next   = htcs_pkg::PH_TODO;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                htcs_pkg::PH_LINE, htcs_pkg::PH_TODO:
                begin
                    if (c == 8'h0d || c == 8'h0a)
                    begin
                        res.kind = htcs_pkg::eof_kind(ph);
                        fin      = 1'b1;
                    end
                    else
                    begin
                        res.consumed = 1'b1;
                        phase_next   = ph;
                    end
                end
                htcs_pkg::PH_BLOCK:
                begin
                    res.consumed = 1'b1;
                    phase_next   = (c == 8'h2a) ? htcs_pkg::PH_BLOCK_STAR : htcs_pkg::PH_BLOCK;
                end
                htcs_pkg::PH_NEST:
                begin
                    res.consumed = 1'b1;
                    phase_next   = (c == 8'h2b) ? htcs_pkg::PH_NEST_PLUS :
                                   (c == 8'h2f) ? htcs_pkg::PH_NEST_SLASH : htcs_pkg::PH_NEST;
                end
                htcs_pkg::PH_LIT_BIN, htcs_pkg::PH_LIT_OCT,
                htcs_pkg::PH_LIT_DEC, htcs_pkg::PH_LIT_HEX:
                begin
                    if (c == 8'h5f || c == 8'h2e ||
                        (ph == htcs_pkg::PH_LIT_BIN && (c == 8'h30 || c == 8'h31)) ||
                        (ph == htcs_pkg::PH_LIT_OCT && htcs_pkg::is_oct(c)) ||
                        (ph == htcs_pkg::PH_LIT_DEC && htcs_pkg::is_dec(c)) ||
                        (ph == htcs_pkg::PH_LIT_HEX && htcs_pkg::is_hex(c)))
                    begin
                        res.consumed = 1'b1;
                        phase_next   = ph;
                    end
                    else
                    begin
                        res.kind = htcs_pkg::eof_kind(ph);
                        fin      = 1'b1;
                    end
                end
                htcs_pkg::PH_ESC_SEL:
                begin
                    res.consumed = 1'b1;
                    if (c == 8'h78 || c == 8'h75 || c == 8'h55)
                    begin
                        cnt_next   = (c == 8'h78) ? 4'd2 : (c == 8'h75) ? 4'd4 : 4'd8;
                        phase_next = htcs_pkg::PH_ESC_HEX;
                    end
                    else if (htcs_pkg::is_oct(c))
                    begin
                        phase_next = htcs_pkg::PH_ESC_OCT;
                    end
                    else if (c == 8'h26)
                    begin
                        phase_next = htcs_pkg::PH_ESC_NAME;
                    end
                    else
                    begin
                        res.kind = htcs_pkg::K_ESCAPE;
                        fin      = 1'b1;
                    end
                end
                htcs_pkg::PH_ESC_HEX:
                begin
                    if (!htcs_pkg::is_hex(c))
                    begin
                        res.kind = htcs_pkg::K_ESCAPE;
                        fin      = 1'b1;
                    end
                    else
                    begin
                        res.consumed = 1'b1;
                        if (cnt_reg <= 4'd1)
                        begin
                            res.kind = htcs_pkg::K_ESCAPE;
                            fin      = 1'b1;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg - 4'd1;
                            phase_next = htcs_pkg::PH_ESC_HEX;
                        end
                    end
                end
                htcs_pkg::PH_ESC_OCT:
                begin
                    if (htcs_pkg::is_oct(c))
                    begin
                        res.consumed = 1'b1;
                        phase_next   = ph;
                    end
                    else
                    begin
                        res.kind = htcs_pkg::K_ESCAPE;
                        fin      = 1'b1;
                    end
                end
                htcs_pkg::PH_ESC_NAME:
                begin
                    if (htcs_pkg::is_letter(c))
                    begin
                        res.consumed = 1'b1;
                        phase_next   = ph;
                    end
                    else
                    begin
                        res.consumed = (c == 8'h3b);
                        res.kind     = htcs_pkg::K_ESCAPE;
                        fin          = 1'b1;
                    end
                end
                htcs_pkg::PH_EXP_DIG:
                begin
                    if (htcs_pkg::is_dec(c))
                    begin
                        res.consumed = 1'b1;
                        phase_next   = ph;
                    end
                    else
                    begin
                        res.kind = htcs_pkg::K_EXPONENT;
                        fin      = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (fin)
        begin
            res.done   = 1'b1;
            phase_next = htcs_pkg::PH_IDLE;
            cnt_next   = 4'd0;
            depth_next = 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= htcs_pkg::PH_IDLE;
            wants_reg  <= '0;
            cnt_reg    <= '0;
            depth_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg <= phase_next;
                wants_reg <= wants_next;
                cnt_reg   <= cnt_next;
                depth_reg <= depth_next;
            end
            if (in_ready)
            begin
                ovalid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

endmodule

>>> src/hdl_token_char_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdl_token_char_scanner
// Token character scanner: one lookahead character per transaction in, one
// result transaction out.
//
// s_axis carries characters; s_axis_tuser is begin_scan, which latches the
// want flags in the same transaction. m_axis returns one result for every
// input transaction, in order. When a result shows token_done without the
// character consumed, the feeder resends that character with begin_scan.
// Throughput: one transaction per cycle while m_axis accepts results. A
// result passes through the input register, the queue and the output
// register on its way to m_axis. A stalled m_axis fills the output
// register, then the two-entry queue, then the input register, after
// which s_axis_tready falls. Reset clears all valid flags and puts the
// scanner in its idle phase with want flags, digit count and nesting
// depth cleared; no scan is active until one is begun.
// ----------------------------------------------------------------------------
module hdl_token_char_scanner #(
    parameter int MAX_NEST_DEPTH = htcs_pkg::MAX_NEST_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // char_code[7:0], end_of_input, want_string_part, want_exponent, want_bin,
    // want_oct, want_dec, want_hex, want_todo, error_recovery, zero[6:0]
    input  logic [23:0] s_axis_tdata,
    // begin_scan
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // char_consumed, char_skipped, token_done, token_kind[3:0], zero
    output logic [7:0]  m_axis_tdata
);

    logic            f_valid, f_ready, e_valid, e_ready;
    htcs_pkg::item_t f_item, e_item;

    htcs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (f_valid),
        .q_ready       (f_ready),
        .q_item        (f_item)
    );

    htcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (e_valid),
        .out_ready (e_ready),
        .out_item  (e_item)
    );

    htcs_engine #(
        .MAX_NEST_DEPTH (MAX_NEST_DEPTH)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (e_valid),
        .in_ready      (e_ready),
        .in_item       (e_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> src/htcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htcs_checker
// Port-level checks of the token character scanner.
// ----------------------------------------------------------------------------
module htcs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    a_kind_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[6:3] == 4'd0)
        else $error("kind without done");

    a_skip_not_consume: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("skipped and consumed");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[6:3] != 4'd15 && !m_axis_tdata[7])
        else $error("bad kind");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");

    a_no_out_without_in: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_axis_tvalid)
        else $error("result after reset");

endmodule

bind hdl_token_char_scanner htcs_checker u_htcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
